FILE: hdl/audio_frame_seek_walker_unit_macros.svh
// ----------------------------------------------------------------------------
// audio_frame_seek_walker_unit_macros.svh
// Assertion macros for the frame seek walker. Clock is clk, reset is rst.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_SEEK_WALKER_UNIT_MACROS_SVH
`define AUDIO_FRAME_SEEK_WALKER_UNIT_MACROS_SVH

`ifndef SYNTH

// property holds at every edge outside reset
`define AFSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AFSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AFSW_ASSERT(lbl, prop, msg)
`define AFSW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/afsw_pkg.sv
// ----------------------------------------------------------------------------
// afsw_pkg
// Shared constants and types of the audio frame seek walker.
// ----------------------------------------------------------------------------
`default_nettype none

package afsw_pkg;

  localparam int RATE_HZ  = 22050;
  localparam int MS_PER_S = 1000;
  localparam int HDR_LEN  = 8;

  // samples = ms * RATE_HZ / MS_PER_S, reduced by the common factor
  localparam int RATE_GCD = 50;
  localparam int TGT_NUM  = RATE_HZ / RATE_GCD;   // 441
  localparam int TGT_DEN  = MS_PER_S / RATE_GCD;  // 20

  // floor(samp * TGT_DEN / TGT_NUM) by reciprocal, at most one low
  localparam int MS_SHIFT = 40;
  localparam int MS_RECIP_W = 36;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP =
    MS_RECIP_W'(((64'd1 << MS_SHIFT) * 64'(TGT_DEN)) / 64'(TGT_NUM));
  localparam int MS_SPLIT = 18;
  localparam int MS_Q_W = 28;

  typedef enum logic [1:0] {
    CFG_TARGET_MS  = 2'd0,
    CFG_TOTAL      = 2'd1,
    CFG_HDR_OFFSET = 2'd2,
    CFG_FILE_LEN   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] sample;
  } landing_t;

endpackage

`default_nettype wire

FILE: hdl/audio_frame_seek_walker_unit.sv
// ----------------------------------------------------------------------------
// audio_frame_seek_walker_unit
// Walks the frame headers of a compressed audio file byte stream and reports
// the frame that holds the requested playback position.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the seek position, total sample count, header offset and file
//   length through the write port (cfg_write, cfg_index, cfg_data). A write
//   applies from the next accepted byte; write only with no result in flight.
//   Stream file bytes on data_byte with start_of_file set on the byte at
//   offset 0. Each transaction on the input channel is one byte; the block
//   takes one byte per cycle while in_ready is high and needs no gaps between bytes.
//   When the walk ends, one result transaction carries landing_offset,
//   landing_sample and landing_ms. It leaves the block through a
//   five-register pipeline; the millisecond conversion (split reciprocal
//   multiply, then a correction) sets that depth.
//   Bytes after the result, or before any start byte, are taken and dropped.
//   Reset: no walk active, header_offset = 8, other registers zero, pipeline
//   empty.
//   A stalled output fills the pipeline; input stays ready until the stage
//   behind the walker holds a result it cannot pass on.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_seek_walker_unit (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_file,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      landing_offset,
  output logic [31:0]      landing_sample,
  output logic [31:0]      landing_ms
);

  `include "audio_frame_seek_walker_unit_macros.svh"

  import afsw_pkg::*;

  localparam int PROD_W = 41;
  localparam int FS20_W = 21;
  localparam int PP_W   = 32 + MS_SPLIT;
  localparam int SUM_W  = PP_W + MS_SPLIT;
  localparam int S20_W  = 37;

  // configuration
  logic [PROD_W-1:0] tgt_prod;
  logic [31:0]       total;
  logic [31:0]       hoff;
  logic [31:0]       flen;

  // walker state
  logic              fin, fin_next;
  logic [31:0]       shreg, shreg_next;
  logic [31:0]       hdr_cnt, hdr_cnt_next;
  logic [31:0]       fstart, fstart_next;
  logic [31:0]       ssum, ssum_next;
  logic [S20_W-1:0]  ssum_x20, ssum_x20_next;

  logic              acc;
  logic              emit;
  landing_t          res;
  logic [31:0]       sh_in;
  logic [15:0]       fs;
  logic [15:0]       sz;
  logic [FS20_W-1:0] fs20;
  logic [32:0]       sum_nx;
  logic [S20_W-1:0]  x20_nx;
  logic [32:0]       end_nx;
  logic [33:0]       hdr_nx;
  logic              past_tgt;
  logic [32:0]       d_sof;

  // result pipeline
  logic              va, vb, vc, vd;
  logic              rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
  landing_t          a_res, b_res, c_res, d_res;
  logic [PP_W-1:0]   b_pp_hi, b_pp_lo;
  logic [S20_W-1:0]  b_s20, c_s20, d_s20;
  logic [SUM_W-1:0]  pp_sum;
  logic [MS_Q_W-1:0] c_q, d_q;
  logic [S20_W-1:0]  d_q441;
  logic [S20_W-1:0]  ms_rem;
  logic [MS_Q_W-1:0] ms_fix;

  assign rdy_o    = !out_valid || out_ready;
  assign rdy_d    = !vd || rdy_o;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_prod <= '0;
      total    <= '0;
      hoff     <= 32'(HDR_LEN);
      flen     <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_MS:  tgt_prod <= {9'd0, cfg_data} * PROD_W'(TGT_NUM);
        CFG_TOTAL:      total    <= cfg_data;
        CFG_HDR_OFFSET: hoff     <= cfg_data;
        CFG_FILE_LEN:   flen     <= cfg_data;
        default:        total    <= total;
      endcase
    end
  end

  assign sh_in  = start_of_file ? {24'd0, data_byte} : {shreg[23:0], data_byte};
  assign fs     = sh_in[31:16];
  assign sz     = sh_in[15:0];
  assign fs20   = (FS20_W'(fs) << 4) + (FS20_W'(fs) << 2);
  assign sum_nx = {1'b0, ssum} + {17'd0, fs};
  assign x20_nx = ssum_x20 + S20_W'(fs20);
  assign end_nx = {1'b0, fstart} + {17'd0, sz};
  assign hdr_nx = {2'd0, fstart} + {18'd0, sz} + 34'(HDR_LEN);
  assign d_sof  = {1'b0, flen} - {1'b0, hoff};

  // zero total clamps the target to all ones
  assign past_tgt = (total == '0) ? sum_nx[32] :
                    (PROD_W'(x20_nx) > tgt_prod || sum_nx >= {1'b0, total});

  always_comb begin
    fin_next      = fin;
    shreg_next    = shreg;
    hdr_cnt_next  = hdr_cnt;
    fstart_next   = fstart;
    ssum_next     = ssum;
    ssum_x20_next = ssum_x20;
    emit          = 1'b0;
    res.offset    = fstart;
    res.sample    = ssum;
    if (acc) begin
      shreg_next = sh_in;
      if (start_of_file) begin
        fin_next      = 1'b0;
        hdr_cnt_next  = hoff + 32'(HDR_LEN - 1);
        fstart_next   = hoff;
        ssum_next     = '0;
        ssum_x20_next = '0;
        res.offset    = hoff;
        res.sample    = '0;
        if (tgt_prod == '0 || total == '0 || d_sof[32] ||
            d_sof[31:0] < 32'(HDR_LEN)) begin
          emit     = 1'b1;
          fin_next = 1'b1;
        end
      end else if (!fin) begin
        hdr_cnt_next = hdr_cnt - 32'd1;
        if (hdr_cnt == 32'd1) begin
          if (sz == '0 || end_nx > {1'b0, flen} || past_tgt) begin
            emit     = 1'b1;
            fin_next = 1'b1;
          end else begin
            fstart_next   = end_nx[31:0];
            ssum_next     = sum_nx[31:0];
            ssum_x20_next = x20_nx;
            hdr_cnt_next  = {16'd0, sz};
            res.offset    = end_nx[31:0];
            res.sample    = sum_nx[31:0];
            if (hdr_nx > {2'd0, flen}) begin
              emit     = 1'b1;
              fin_next = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin       <= 1'b1;
      shreg     <= '0;
      hdr_cnt   <= '0;
      fstart    <= '0;
      ssum      <= '0;
      ssum_x20  <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fin      <= fin_next;
      shreg    <= shreg_next;
      hdr_cnt  <= hdr_cnt_next;
      fstart   <= fstart_next;
      ssum     <= ssum_next;
      ssum_x20 <= ssum_x20_next;
      if (rdy_a) begin
        va <= emit;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        vc <= vb;
      end
      if (rdy_d) begin
        vd <= vc;
      end
      if (rdy_o) begin
        out_valid <= vd;
      end
    end
  end

  assign pp_sum = (SUM_W'(b_pp_hi) << MS_SPLIT) + SUM_W'(b_pp_lo);
  assign ms_rem = d_s20 - d_q441;
  assign ms_fix = d_q + MS_Q_W'(ms_rem >= S20_W'(TGT_NUM));

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_res <= res;
    end
    if (rdy_b) begin
      b_res   <= a_res;
      b_pp_hi <= PP_W'(a_res.sample) * PP_W'(MS_RECIP[MS_RECIP_W-1:MS_SPLIT]);
      b_pp_lo <= PP_W'(a_res.sample) * PP_W'(MS_RECIP[MS_SPLIT-1:0]);
      b_s20   <= (S20_W'(a_res.sample) << 4) + (S20_W'(a_res.sample) << 2);
    end
    if (rdy_c) begin
      c_res <= b_res;
      c_s20 <= b_s20;
      c_q   <= pp_sum[SUM_W-1:MS_SHIFT];
    end
    if (rdy_d) begin
      d_res  <= c_res;
      d_s20  <= c_s20;
      d_q    <= c_q;
      d_q441 <= S20_W'(c_q) * S20_W'(TGT_NUM);
    end
    if (rdy_o) begin
      landing_offset <= d_res.offset;
      landing_sample <= d_res.sample;
      landing_ms     <= 32'(ms_fix);
    end
  end

  `AFSW_ASSERT(a_x20_sum, ssum_x20 == (S20_W'(ssum) << 4) + (S20_W'(ssum) << 2), "x20 sum drift")
  `AFSW_ASSERT(a_cnt_live, fin || hdr_cnt != '0, "header countdown reached zero")
  `AFSW_ASSERT_NEXT(a_emit_fin, acc && emit, fin, "walk not closed after result")
  `AFSW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped on stall")
  `AFSW_ASSERT(a_ms_recip, !vd || ms_rem < S20_W'(2 * TGT_NUM), "ms reciprocal off by more than one")

endmodule

`default_nettype wire

FILE: verif/afsw_seek_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// afsw_seek_scoreboard_pkg
// Scoreboard for the frame seek walker: tracks the walk byte by byte and
// queues the landing each accepted byte produces, then checks the landings
// that come out of the block against that queue in order.
// ----------------------------------------------------------------------------
package afsw_seek_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import afsw_pkg::*;

  typedef struct {
    logic [31:0] offset;
    logic [31:0] sample;
    logic [31:0] ms;
  } landing_rec_t;

  class seek_scoreboard;
    logic [31:0] tgt_ms;
    logic [31:0] tot_samp;
    logic [31:0] hdr_off;
    logic [31:0] file_len;
    logic [31:0] pos;
    logic [31:0] frm_start;
    logic [31:0] run_sum;
    logic [15:0] cnt_sr;
    logic [15:0] size_sr;
    bit walk_done;
    landing_rec_t landings_due[$];
    int unsigned errors;

    function new();
      tgt_ms = '0;
      tot_samp = '0;
      hdr_off = 32'(HDR_LEN);
      file_len = '0;
      pos = '0;
      frm_start = '0;
      run_sum = '0;
      cnt_sr = '0;
      size_sr = '0;
      walk_done = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_TARGET_MS:  tgt_ms = v;
        CFG_TOTAL:      tot_samp = v;
        CFG_HDR_OFFSET: hdr_off = v;
        CFG_FILE_LEN:   file_len = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] seek_sample();
      logic [63:0] t;
      t = {32'b0, tgt_ms} * 64'(RATE_HZ) / 64'(MS_PER_S);
      if (t >= {32'b0, tot_samp}) t = {32'b0, tot_samp} - 64'd1;
      return t[31:0];
    endfunction

    function bit header_fits();
      return {32'b0, frm_start} + 64'(HDR_LEN) <= {32'b0, file_len};
    endfunction

    function void land();
      landing_rec_t r;
      logic [63:0] m;
      m = {32'b0, run_sum} * 64'(MS_PER_S) / 64'(RATE_HZ);
      r.offset = frm_start;
      r.sample = run_sum;
      r.ms = m[31:0];
      landings_due.push_back(r);
      walk_done = 1'b1;
    endfunction

    // returns 0 when the byte is dropped by the block
    function bit walk_byte(logic [7:0] b, bit sof);
      if (!sof && walk_done) return 1'b0;
      if (sof) begin
        pos = '0;
        frm_start = hdr_off;
        cnt_sr = '0;
        size_sr = '0;
        run_sum = '0;
        walk_done = 1'b0;
      end else if (pos != 32'hFFFF_FFFF) begin
        pos++;
      end
      cnt_sr = {cnt_sr[7:0], size_sr[15:8]};
      size_sr = {size_sr[7:0], b};
      if (sof && (tgt_ms == 0 || tot_samp == 0 || !header_fits())) begin
        land();
      end else if ({32'b0, pos} == {32'b0, frm_start} + 64'(HDR_LEN - 1)) begin
        if (size_sr == 0 || {32'b0, frm_start} + {48'b0, size_sr} > {32'b0, file_len}) begin
          land();
        end else if ({32'b0, run_sum} + {48'b0, cnt_sr} > {32'b0, seek_sample()}) begin
          land();
        end else begin
          frm_start += {16'b0, size_sr};
          run_sum += {16'b0, cnt_sr};
          if (!header_fits()) land();
        end
      end
      return 1'b1;
    endfunction

    function void check_landing(logic [31:0] off, logic [31:0] smp, logic [31:0] ms);
      landing_rec_t want;
      if (landings_due.size() == 0) begin
        $display("%0t: unexpected landing offset=%0h sample=%0h ms=%0h",
                 $time, off, smp, ms);
        errors++;
        return;
      end
      want = landings_due.pop_front();
      if (want.offset !== off) begin
        $display("%0t: landing_offset expected %0h actual %0h", $time, want.offset, off);
        errors++;
      end
      if (want.sample !== smp) begin
        $display("%0t: landing_sample expected %0h actual %0h", $time, want.sample, smp);
        errors++;
      end
      if (want.ms !== ms) begin
        $display("%0t: landing_ms expected %0h actual %0h", $time, want.ms, ms);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_audio_frame_seek_walker_unit.sv
// ----------------------------------------------------------------------------
// tb_audio_frame_seek_walker_unit
// Streams synthetic audio files with random frame headers, offsets, lengths
// and seek targets into the walker under random source and sink stalls, and
// checks every landing transaction against the scoreboard's own walk.
// ----------------------------------------------------------------------------
module tb_audio_frame_seek_walker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afsw_pkg::*;
  import afsw_seek_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        start_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] landing_offset;
  logic [31:0] landing_sample;
  logic [31:0] landing_ms;

  seek_scoreboard sb = new();
  int unsigned fed = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  bit sink_hold = 1'b0;

  audio_frame_seek_walker_unit dut (.*);

  always #6 clk = ~clk;

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_landing(landing_offset, landing_sample, landing_ms);
  end

  initial begin : result_sink
    int unsigned w;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        w = quiet_out ? 0 : $urandom_range(0, 7);
        if (w != 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit sof);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_file <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.walk_byte(b, sof)) fed++;
  endtask

  // drain all landings, then give the pipeline time to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.landings_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_walk(input logic [31:0] tm, input logic [31:0] tot,
                              input logic [31:0] ho, input logic [31:0] fl);
    logic [31:0] vals [4];
    vals = '{tm, tot, ho, fl};
    cfg_write <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      sb.set_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_file();
    logic [7:0]  img [256];
    logic [15:0] smp;
    logic [15:0] sz;
    logic [31:0] ho_reg;
    logic [31:0] tm;
    logic [31:0] tot;
    logic [31:0] fl;
    int unsigned ho, pos, len, sum, max_ms, send_len, nfr;
    int tail;
    bit sof;
    for (int i = 0; i < 256; i++) img[i] = $urandom;
    ho = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    pos = ho;
    sum = 0;
    sz = 16'd8;
    nfr = $urandom_range(1, 5);
    for (int f = 0; f < nfr; f++) begin
      case ($urandom_range(0, 19))
        0:       sz = 16'd0;
        1, 2:    sz = 16'($urandom_range(1, 7));
        default: sz = 16'($urandom_range(8, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       smp = 16'h0000;
        1:       smp = 16'hFFFF;
        default: smp = 16'($urandom_range(1, 3000));
      endcase
      img[pos + 4] = smp[15:8];
      img[pos + 5] = smp[7:0];
      img[pos + 6] = sz[15:8];
      img[pos + 7] = sz[7:0];
      sum += smp;
      if (sz == 0) break;
      pos += sz;
    end
    len = (sz == 0) ? pos + 8 : pos;

    ho_reg = ho;
    case ($urandom_range(0, 7))
      0:       fl = (len > 10) ? len - $urandom_range(1, 10) : len;
      1:       fl = len + $urandom_range(0, 20);
      default: fl = len;
    endcase
    if ($urandom_range(0, 39) == 0) begin
      case ($urandom_range(0, 2))
        0:       ho_reg = 32'hFFFF_FFFF;
        1:       ho_reg = 32'hFFFF_FFF8;
        default: ho_reg = 32'hFFFF_FFF7;
      endcase
      fl = 32'hFFFF_FFFF;
    end else if ($urandom_range(0, 29) == 0) begin
      fl = 32'hFFFF_FFFF;
    end

    case ($urandom_range(0, 7))
      0:       tot = 32'hFFFF_FFFF;
      1:       tot = $urandom_range(1, sum + 10);
      default: tot = sum;
    endcase
    max_ms = sum * 1000 / 22050 + 2;
    case ($urandom_range(0, 15))
      0:       tm = 32'd0;
      1:       tm = 32'hFFFF_FFFF;
      default: tm = $urandom_range(1, max_ms);
    endcase

    settle();
    quiet_in = ($urandom_range(0, 3) == 0);
    quiet_out = ($urandom_range(0, 3) == 0);
    program_walk(tm, tot, ho_reg, fl);

    send_len = (len + 16 > 256) ? 256 : len + 16;
    if ($urandom_range(0, 11) == 0) send_len = $urandom_range(1, send_len);
    tail = -1;
    for (int i = 0; i < send_len; i++) begin
      sof = (i == 0) || ($urandom_range(0, 299) == 0);
      push_byte(img[i], sof);
      if (sb.walk_done) begin
        if (tail < 0) tail = $urandom_range(0, 3);
        if (tail == 0) break;
        tail--;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] seq [16];
    int phase;
    seq = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h08,
            8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h12, 8'h34, 8'h00, 8'h00};
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_TARGET_MS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    start_of_file <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // bytes before any start are dropped; reset target of zero lands at once
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);

    // zero total
    settle();
    program_walk(32'd1000, 32'd0, 32'd0, 32'd100);
    push_byte(8'h3C, 1'b1);

    // header offset at the top of the range: no room for a header
    settle();
    program_walk('1, '1, '1, '1);
    push_byte(8'hC3, 1'b1);

    // restart mid-walk, one full frame, then a zero-size frame
    settle();
    program_walk('1, '1, 32'd0, '1);
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    for (int i = 0; i < 16; i++) push_byte(seq[i], i == 0);
    push_byte(8'h77, 1'b0);

    phase = 0;
    while (fed < 1200) begin
      if (phase == 6) begin
        // back to back start bytes that all land while the sink holds off
        settle();
        quiet_in = 1'b1;
        program_walk(32'd0, 32'd5, $urandom_range(0, 99), 32'd100);
        sink_hold = 1'b1;
        repeat (24) push_byte($urandom, 1'b1);
      end
      run_file();
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.landings_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.landings_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
